// ----- rtl/core/lass_pkg.sv -----
`timescale 1ns / 1ps

package lass_pkg;

    // field widths
    localparam int CFG_W   = 6;
    localparam int ADDR_W  = 2;
    localparam int SEQ_W   = 32;
    localparam int ACC_W   = 7;
    localparam int BND_W   = 8;

    // sequence length limits
    localparam int MAX_LEN_DEF = 32;
    localparam int MIN_LEN     = 2;

    // register indexes
    localparam logic [ADDR_W-1:0] REG_SEQ_LENGTH    = 2'd0;
    localparam logic [ADDR_W-1:0] REG_TARGET_WEIGHT = 2'd1;
    localparam logic [ADDR_W-1:0] REG_MAX_CORR      = 2'd2;

    // register reset values
    localparam logic [CFG_W-1:0] RST_SEQ_LENGTH    = 6'd16;
    localparam logic [CFG_W-1:0] RST_TARGET_WEIGHT = 6'd8;
    localparam logic [CFG_W-1:0] RST_MAX_CORR      = 6'd4;

    typedef enum logic [2:0] {
        ST_WAIT,
        ST_ENTER,
        ST_ECHK,
        ST_PCHK,
        ST_BACK,
        ST_ZERO,
        ST_ZCHK,
        ST_EMIT
    } t_state;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_PAUSED,
        PH_DONE
    } t_phase;

    typedef enum logic {
        CS_IDLE,
        CS_RUN
    } t_corr_state;

    typedef struct packed {
        logic             start;
        logic             periodic;
        logic [CFG_W-1:0] n;
        logic [CFG_W-1:0] len;
        logic [CFG_W-1:0] max_corr;
    } t_corr_cmd;

    typedef struct packed {
        logic done;
        logic ok;
    } t_corr_sts;

endpackage

// ----- rtl/core/lass_if.sv -----
`timescale 1ns / 1ps

// search request channel
interface lass_req_if;
    logic valid;
    logic ready;
    logic restart;

    modport source (output valid, output restart, input ready);
    modport sink (input valid, input restart, output ready);
endinterface

// search result channel
interface lass_res_if;
    logic                     valid;
    logic                     ready;
    logic [lass_pkg::SEQ_W-1:0] sequence_res;
    logic                     found;

    modport source (output valid, output sequence_res, output found, input ready);
    modport sink (input valid, input sequence_res, input found, output ready);
endinterface

// register write channel
interface lass_cfg_if;
    logic                        valid;
    logic                        ready;
    logic [lass_pkg::ADDR_W-1:0] addr;
    logic [lass_pkg::CFG_W-1:0]  data;

    modport source (output valid, output addr, output data, input ready);
    modport sink (input valid, input addr, input data, output ready);
endinterface

// ----- rtl/core/lass_corr.sv -----
`timescale 1ns / 1ps

// bit-serial correlator: one product term per cycle, one shift per row
module lass_corr #(
    parameter int MAX_LEN = lass_pkg::MAX_LEN_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  lass_pkg::t_corr_cmd  i_cmd,
    input  logic [MAX_LEN-1:0]   i_seq,
    output lass_pkg::t_corr_sts  o_sts
);

    localparam int IDX_W = $clog2(MAX_LEN);
    localparam int CFG_W = lass_pkg::CFG_W;
    localparam int ACC_W = lass_pkg::ACC_W;
    localparam int BND_W = lass_pkg::BND_W;

    lass_pkg::t_corr_state r_cst, n_cst;
    logic                     r_done, n_done;
    logic                     r_ok, n_ok;
    logic                     r_periodic, n_periodic;
    logic [CFG_W-1:0]         r_n, n_n;
    logic [BND_W-1:0]         r_bound, n_bound;
    logic [IDX_W-1:0]         r_u, n_u;
    logic [IDX_W-1:0]         r_i, n_i;
    logic signed [ACC_W-1:0]  r_acc, n_acc;

    logic [CFG_W-1:0]         j_sum;
    logic [CFG_W-1:0]         j_idx;
    logic                     same;
    logic signed [ACC_W-1:0]  acc_nxt;
    logic [ACC_W-1:0]         acc_abs;
    logic                     over;
    logic [CFG_W-1:0]         last_i;
    logic [CFG_W-1:0]         last_u;
    logic                     row_end;
    logic                     col_end;
    logic                     short_pfx;

    // partner index, wrapped for the periodic form
    assign j_sum   = CFG_W'(r_i) + CFG_W'(r_u);
    assign j_idx   = (r_periodic && (j_sum >= r_n)) ? (j_sum - r_n) : j_sum;
    assign same    = (i_seq[r_i] == i_seq[j_idx[IDX_W-1:0]]);
    assign acc_nxt = same ? (r_acc + ACC_W'(1)) : (r_acc - ACC_W'(1));
    assign acc_abs = acc_nxt[ACC_W-1] ? ACC_W'(-acc_nxt) : ACC_W'(acc_nxt);
    assign over    = (BND_W'(acc_abs) > r_bound);

    assign last_i  = r_periodic ? (r_n - CFG_W'(1))
                                : (r_n - CFG_W'(1) - CFG_W'(r_u));
    assign last_u  = r_periodic ? {1'b0, r_n[CFG_W-1:1]} : (r_n - CFG_W'(1));
    assign row_end = (CFG_W'(r_i) == last_i);
    assign col_end = (CFG_W'(r_u) == last_u);

    assign short_pfx = !i_cmd.periodic && (i_cmd.n < CFG_W'(lass_pkg::MIN_LEN));

    always_comb begin
        n_cst = r_cst;
        unique case (r_cst)
            lass_pkg::CS_IDLE: begin
                if (i_cmd.start && !short_pfx) begin
                    n_cst = lass_pkg::CS_RUN;
                end
            end
            lass_pkg::CS_RUN: begin
                if (row_end && (over || col_end)) begin
                    n_cst = lass_pkg::CS_IDLE;
                end
            end
            default: n_cst = lass_pkg::CS_IDLE;
        endcase
    end

    always_comb begin
        n_done     = 1'b0;
        n_ok       = r_ok;
        n_periodic = r_periodic;
        n_n        = r_n;
        n_bound    = r_bound;
        n_u        = r_u;
        n_i        = r_i;
        n_acc      = r_acc;
        unique case (r_cst)
            lass_pkg::CS_IDLE: begin
                if (i_cmd.start) begin
                    n_periodic = i_cmd.periodic;
                    n_n        = i_cmd.n;
                    // prefix slack: bits still to be placed
                    n_bound    = BND_W'(i_cmd.max_corr)
                               + (i_cmd.periodic ? BND_W'(0)
                                                 : (BND_W'(i_cmd.len) - BND_W'(i_cmd.n)));
                    n_u        = IDX_W'(1);
                    n_i        = '0;
                    n_acc      = '0;
                    if (short_pfx) begin
                        n_done = 1'b1;
                        n_ok   = 1'b1;
                    end
                end
            end
            lass_pkg::CS_RUN: begin
                if (row_end) begin
                    if (over) begin
                        n_done = 1'b1;
                        n_ok   = 1'b0;
                    end else if (col_end) begin
                        n_done = 1'b1;
                        n_ok   = 1'b1;
                    end else begin
                        n_u   = r_u + IDX_W'(1);
                        n_i   = '0;
                        n_acc = '0;
                    end
                end else begin
                    n_i   = r_i + IDX_W'(1);
                    n_acc = acc_nxt;
                end
            end
            default: n_done = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cst  <= lass_pkg::CS_IDLE;
            r_done <= 1'b0;
        end else begin
            r_cst  <= n_cst;
            r_done <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ok       <= n_ok;
        r_periodic <= n_periodic;
        r_n        <= n_n;
        r_bound    <= n_bound;
        r_u        <= n_u;
        r_i        <= n_i;
        r_acc      <= n_acc;
    end

    assign o_sts.done = r_done;
    assign o_sts.ok   = r_ok;

endmodule

// ----- rtl/core/low_autocorrelation_sequence_search.sv -----
`timescale 1ns / 1ps

// channel   dir  modport  payload                     request meaning
// i_req     in   sink     restart                     find next sequence (1: from scratch)
// o_res     out  source   sequence_res[31:0], found   next hit, or found=0 when exhausted
// i_cfg     in   sink     addr[1:0], data[5:0]        register write, always ready
//
// each tree node costs a pass through the control states plus one pass of the
// bit-serial correlator: aperiodic over an n-bit prefix, periodic over shifts
// 1..L/2 at a leaf; a request therefore takes a data-dependent time to
// search; one request is searched at a time
// reset is synchronous, active low, and loads the register defaults
// a finished result waits in the output register; the next request is taken
// meanwhile and its search only stalls when it has another result to hand over
module low_autocorrelation_sequence_search #(
    parameter int MAX_LEN = lass_pkg::MAX_LEN_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    lass_req_if.sink       i_req,
    lass_res_if.source     o_res,
    lass_cfg_if.sink       i_cfg
);

    localparam int LEN_W = $clog2(MAX_LEN + 1);
    localparam int IDX_W = $clog2(MAX_LEN);
    localparam int CFG_W = lass_pkg::CFG_W;
    localparam int SEQ_W = lass_pkg::SEQ_W;
    localparam int BND_W = lass_pkg::BND_W;

    // search control
    lass_pkg::t_state r_state, n_state;
    lass_pkg::t_phase r_phase, n_phase;

    // configuration registers
    logic [CFG_W-1:0]   r_seq_length, n_seq_length;
    logic [CFG_W-1:0]   r_target, n_target;
    logic [CFG_W-1:0]   r_max_corr, n_max_corr;

    // search tree position
    logic [MAX_LEN-1:0] r_seq, n_seq;
    logic [LEN_W-1:0]   r_depth, n_depth;
    logic [LEN_W-1:0]   r_ones, n_ones;
    logic [MAX_LEN-1:0] r_marks, n_marks;
    logic               r_hit, n_hit;

    // output register
    logic               r_res_valid, n_res_valid;
    logic [SEQ_W-1:0]   r_res_seq, n_res_seq;
    logic               r_res_found, n_res_found;

    logic                req_acc;
    logic                cfg_wr;
    logic                res_load;
    logic [LEN_W-1:0]    len_eff;
    logic [LEN_W-1:0]    room;
    logic [LEN_W-1:0]    dm1;
    logic [LEN_W-1:0]    dp1;
    logic                prune;
    logic                at_leaf;
    logic [SEQ_W-1:0]    seq_wide;
    lass_pkg::t_corr_cmd corr_cmd;
    lass_pkg::t_corr_sts corr_sts;

    assign i_req.ready = (r_state == lass_pkg::ST_WAIT);
    assign i_cfg.ready = 1'b1;
    assign req_acc     = i_req.valid && i_req.ready;
    assign cfg_wr      = i_cfg.valid && i_cfg.ready;

    // out-of-range lengths are clamped
    always_comb begin
        if (r_seq_length < CFG_W'(lass_pkg::MIN_LEN)) begin
            len_eff = LEN_W'(lass_pkg::MIN_LEN);
        end else if (r_seq_length > CFG_W'(MAX_LEN)) begin
            len_eff = LEN_W'(MAX_LEN);
        end else begin
            len_eff = r_seq_length[LEN_W-1:0];
        end
    end

    assign room    = len_eff - r_depth;
    assign dm1     = r_depth - LEN_W'(1);
    assign dp1     = r_depth + LEN_W'(1);
    assign at_leaf = (r_depth == len_eff);

    // weight can no longer land on the target
    assign prune = (BND_W'(r_ones) > BND_W'(r_target))
                || ((BND_W'(r_ones) + BND_W'(room)) < BND_W'(r_target));

    // free slot in the output register
    assign res_load = (r_state == lass_pkg::ST_EMIT) && (!r_res_valid || o_res.ready);

    always_comb begin
        seq_wide = '0;
        seq_wide[MAX_LEN-1:0] = r_seq;
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            lass_pkg::ST_WAIT: begin
                if (req_acc) begin
                    if (i_req.restart || (r_phase == lass_pkg::PH_IDLE)) begin
                        n_state = lass_pkg::ST_ENTER;
                    end else if (r_phase == lass_pkg::PH_DONE) begin
                        n_state = lass_pkg::ST_EMIT;
                    end else begin
                        n_state = lass_pkg::ST_BACK;
                    end
                end
            end
            lass_pkg::ST_ENTER: begin
                if (prune) begin
                    n_state = lass_pkg::ST_BACK;
                end else if (at_leaf) begin
                    n_state = lass_pkg::ST_PCHK;
                end else begin
                    n_state = lass_pkg::ST_ECHK;
                end
            end
            lass_pkg::ST_ECHK: begin
                if (corr_sts.done) begin
                    n_state = corr_sts.ok ? lass_pkg::ST_ENTER : lass_pkg::ST_ZERO;
                end
            end
            lass_pkg::ST_ZCHK: begin
                if (corr_sts.done) begin
                    n_state = corr_sts.ok ? lass_pkg::ST_ENTER : lass_pkg::ST_BACK;
                end
            end
            lass_pkg::ST_PCHK: begin
                if (corr_sts.done) begin
                    n_state = corr_sts.ok ? lass_pkg::ST_EMIT : lass_pkg::ST_BACK;
                end
            end
            lass_pkg::ST_BACK: begin
                if (r_depth == '0) begin
                    n_state = lass_pkg::ST_EMIT;
                end else begin
                    // 1-branch used up goes on to the 0-branch, else climb further
                    n_state = r_marks[dm1[IDX_W-1:0]] ? lass_pkg::ST_BACK
                                                      : lass_pkg::ST_ZERO;
                end
            end
            lass_pkg::ST_ZERO: begin
                n_state = lass_pkg::ST_ZCHK;
            end
            lass_pkg::ST_EMIT: begin
                if (res_load) begin
                    n_state = lass_pkg::ST_WAIT;
                end
            end
            default: n_state = lass_pkg::ST_WAIT;
        endcase
    end

    // datapath and outputs
    always_comb begin
        n_phase      = r_phase;
        n_seq_length = r_seq_length;
        n_target     = r_target;
        n_max_corr   = r_max_corr;
        n_seq        = r_seq;
        n_depth      = r_depth;
        n_ones       = r_ones;
        n_marks      = r_marks;
        n_hit        = r_hit;
        n_res_seq    = r_res_seq;
        n_res_found  = r_res_found;
        n_res_valid  = o_res.ready ? 1'b0 : r_res_valid;

        corr_cmd.start    = 1'b0;
        corr_cmd.periodic = 1'b0;
        corr_cmd.n        = CFG_W'(dp1);
        corr_cmd.len      = CFG_W'(len_eff);
        corr_cmd.max_corr = r_max_corr;

        unique case (r_state)
            lass_pkg::ST_WAIT: begin
                if (req_acc) begin
                    if (i_req.restart || (r_phase == lass_pkg::PH_IDLE)) begin
                        n_seq   = '0;
                        n_depth = '0;
                        n_ones  = '0;
                        n_marks = '0;
                    end else if (r_phase == lass_pkg::PH_DONE) begin
                        n_hit = 1'b0;
                    end else if (r_depth > len_eff) begin
                        n_depth = len_eff;
                    end
                end
            end
            lass_pkg::ST_ENTER: begin
                if (!prune) begin
                    if (at_leaf) begin
                        corr_cmd.start    = 1'b1;
                        corr_cmd.periodic = 1'b1;
                        corr_cmd.n        = CFG_W'(len_eff);
                    end else begin
                        // try the 1-branch first
                        n_seq[r_depth[IDX_W-1:0]]   = 1'b1;
                        n_marks[r_depth[IDX_W-1:0]] = 1'b0;
                        corr_cmd.start              = 1'b1;
                    end
                end
            end
            lass_pkg::ST_ECHK: begin
                if (corr_sts.done && corr_sts.ok) begin
                    n_ones  = r_ones + LEN_W'(1);
                    n_depth = dp1;
                end
            end
            lass_pkg::ST_ZCHK: begin
                if (corr_sts.done && corr_sts.ok) begin
                    n_depth = dp1;
                end
            end
            lass_pkg::ST_PCHK: begin
                if (corr_sts.done && corr_sts.ok) begin
                    n_hit   = 1'b1;
                    n_phase = lass_pkg::PH_PAUSED;
                end
            end
            lass_pkg::ST_BACK: begin
                if (r_depth == '0) begin
                    n_hit   = 1'b0;
                    n_phase = lass_pkg::PH_DONE;
                end else begin
                    n_depth = dm1;
                    if (r_seq[dm1[IDX_W-1:0]] && (r_ones != '0)) begin
                        n_ones = r_ones - LEN_W'(1);
                    end
                end
            end
            lass_pkg::ST_ZERO: begin
                n_seq[r_depth[IDX_W-1:0]]   = 1'b0;
                n_marks[r_depth[IDX_W-1:0]] = 1'b1;
                corr_cmd.start              = 1'b1;
            end
            lass_pkg::ST_EMIT: begin
                if (res_load) begin
                    n_res_valid = 1'b1;
                    n_res_seq   = r_hit ? seq_wide : '0;
                    n_res_found = r_hit;
                end
            end
            default: n_hit = r_hit;
        endcase

        // any known register write drops back to a fresh search
        if (cfg_wr) begin
            unique case (i_cfg.addr)
                lass_pkg::REG_SEQ_LENGTH: begin
                    n_seq_length = i_cfg.data;
                    n_phase      = lass_pkg::PH_IDLE;
                end
                lass_pkg::REG_TARGET_WEIGHT: begin
                    n_target = i_cfg.data;
                    n_phase  = lass_pkg::PH_IDLE;
                end
                lass_pkg::REG_MAX_CORR: begin
                    n_max_corr = i_cfg.data;
                    n_phase    = lass_pkg::PH_IDLE;
                end
                default: n_phase = n_phase;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= lass_pkg::ST_WAIT;
            r_phase      <= lass_pkg::PH_IDLE;
            r_seq_length <= lass_pkg::RST_SEQ_LENGTH;
            r_target     <= lass_pkg::RST_TARGET_WEIGHT;
            r_max_corr   <= lass_pkg::RST_MAX_CORR;
            r_seq        <= '0;
            r_depth      <= '0;
            r_ones       <= '0;
            r_marks      <= '0;
            r_hit        <= 1'b0;
            r_res_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_phase      <= n_phase;
            r_seq_length <= n_seq_length;
            r_target     <= n_target;
            r_max_corr   <= n_max_corr;
            r_seq        <= n_seq;
            r_depth      <= n_depth;
            r_ones       <= n_ones;
            r_marks      <= n_marks;
            r_hit        <= n_hit;
            r_res_valid  <= n_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_res_seq   <= n_res_seq;
        r_res_found <= n_res_found;
    end

    assign o_res.valid        = r_res_valid;
    assign o_res.sequence_res = r_res_seq;
    assign o_res.found        = r_res_found;

    lass_corr #(
        .MAX_LEN (MAX_LEN)
    ) u_corr (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (corr_cmd),
        .i_seq   (r_seq),
        .o_sts   (corr_sts)
    );

    // correlator only reports while the search waits on it
    a_done_in_check: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        corr_sts.done |-> (r_state == lass_pkg::ST_ECHK || r_state == lass_pkg::ST_ZCHK
                           || r_state == lass_pkg::ST_PCHK))
        else $error("correlator result outside a check state");

    // a check result always moves the search on
    a_done_leaves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        corr_sts.done |=> !(r_state == lass_pkg::ST_ECHK || r_state == lass_pkg::ST_ZCHK
                            || r_state == lass_pkg::ST_PCHK))
        else $error("search stuck after correlator result");

    // an accepted request always starts work
    a_req_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        req_acc |=> (r_state != lass_pkg::ST_WAIT))
        else $error("request accepted but search did not start");

endmodule

// ----- dv/tb_low_autocorrelation_sequence_search.sv -----
`timescale 1ns / 1ps

module tb_low_autocorrelation_sequence_search;

    // minimum number of random requests after the directed tests
    localparam int RANDOM_REQUESTS = 124;

    // register index with no register behind it
    localparam logic [lass_pkg::ADDR_W-1:0] REG_SPARE = 2'd3;

    // a search result as the block hands it over
    typedef struct {
        logic [lass_pkg::SEQ_W-1:0] seq;
        logic                       found;
    } t_hit;

    // what the search walk does next
    typedef enum int {
        WALK_ENTER,
        WALK_BACK,
        WALK_ZERO
    } t_walk_mode;

    logic i_clk;
    logic i_rst_n;

    lass_req_if req_ch ();
    lass_res_if res_ch ();
    lass_cfg_if cfg_ch ();

    low_autocorrelation_sequence_search dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_res   (res_ch),
        .i_cfg   (cfg_ch)
    );

    // register copy
    logic [lass_pkg::CFG_W-1:0] cfg_len;
    logic [lass_pkg::CFG_W-1:0] cfg_weight;
    logic [lass_pkg::CFG_W-1:0] cfg_corr;

    // search state copy
    logic [lass_pkg::SEQ_W-1:0] walk_bits;
    int                         walk_depth;
    int                         walk_ones;
    bit                         walk_marks [lass_pkg::MAX_LEN_DEF];
    lass_pkg::t_phase           walk_phase;

    // sequences still owed by the block, oldest first
    t_hit hits_due [$];
    int   mismatch_count;
    // when clear, neither side inserts gaps or stalls
    bit   idle_on;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // hard stop in case the block hangs
    initial begin
        #1_500_000_000;
        $display("Mismatches found");
        $finish;
    end

    // ---------------------------------------------------------------
    // search predictor
    // ---------------------------------------------------------------

    function automatic void clear_walk();
        walk_bits  = '0;
        walk_depth = 0;
        walk_ones  = 0;
        for (int k = 0; k < lass_pkg::MAX_LEN_DEF; k++) walk_marks[k] = 1'b0;
    endfunction

    function automatic void reset_search_model();
        cfg_len    = lass_pkg::RST_SEQ_LENGTH;
        cfg_weight = lass_pkg::RST_TARGET_WEIGHT;
        cfg_corr   = lass_pkg::RST_MAX_CORR;
        clear_walk();
        walk_phase = lass_pkg::PH_IDLE;
    endfunction

    // any write to a known register drops the search back to idle
    function automatic void store_reg(input logic [lass_pkg::ADDR_W-1:0] idx,
                                      input logic [lass_pkg::CFG_W-1:0] val);
        case (idx)
            lass_pkg::REG_SEQ_LENGTH:    cfg_len = val;
            lass_pkg::REG_TARGET_WEIGHT: cfg_weight = val;
            lass_pkg::REG_MAX_CORR:      cfg_corr = val;
            default:                     return;
        endcase
        walk_phase = lass_pkg::PH_IDLE;
    endfunction

    // aperiodic correlations of the n-bit prefix, with slack for the unfilled tail
    function automatic bit prefix_fits(input int n, input int len);
        int acc;
        if (n < 2) return 1'b1;
        for (int u = 1; u < n; u++) begin
            acc = 0;
            for (int i = 0; i + u < n; i++)
                acc += (walk_bits[i] == walk_bits[i + u]) ? 1 : -1;
            if ((acc < 0 ? -acc : acc) - (len - n) > int'(cfg_corr)) return 1'b0;
        end
        return 1'b1;
    endfunction

    // periodic correlations of the full sequence for shifts 1..len/2
    function automatic bit ring_fits(input int len);
        int acc;
        for (int u = 1; u <= len / 2; u++) begin
            acc = 0;
            for (int i = 0; i < len; i++)
                acc += (walk_bits[i] == walk_bits[(i + u) % len]) ? 1 : -1;
            if ((acc < 0 ? -acc : acc) > int'(cfg_corr)) return 1'b0;
        end
        return 1'b1;
    endfunction

    // resume the depth-first walk and return the next accepted sequence
    function automatic t_hit next_sequence(input logic restart);
        t_hit       r;
        int         len;
        int         d;
        int         tgt;
        t_walk_mode mode;
        len = int'(cfg_len);
        tgt = int'(cfg_weight);
        // length clamps into the supported range
        if (len < lass_pkg::MIN_LEN) len = lass_pkg::MIN_LEN;
        if (len > lass_pkg::MAX_LEN_DEF) len = lass_pkg::MAX_LEN_DEF;
        r.seq   = '0;
        r.found = 1'b0;
        if (restart || walk_phase == lass_pkg::PH_IDLE) begin
            clear_walk();
            mode = WALK_ENTER;
        end else if (walk_phase == lass_pkg::PH_DONE) begin
            // exhausted stays exhausted until restart or a register write
            return r;
        end else begin
            mode = WALK_BACK;
        end
        d = walk_depth;
        if (d > len) d = len;
        forever begin
            case (mode)
                WALK_ENTER: begin
                    if (walk_ones > tgt || walk_ones + (len - d) < tgt) begin
                        mode = WALK_BACK;
                    end else if (d == len) begin
                        if (ring_fits(len)) begin
                            walk_depth = d;
                            walk_phase = lass_pkg::PH_PAUSED;
                            r.seq      = walk_bits;
                            r.found    = 1'b1;
                            return r;
                        end
                        mode = WALK_BACK;
                    end else begin
                        // the one branch goes first
                        walk_bits[d]  = 1'b1;
                        walk_marks[d] = 1'b0;
                        if (prefix_fits(d + 1, len)) begin
                            walk_ones++;
                            d++;
                        end else begin
                            mode = WALK_ZERO;
                        end
                    end
                end
                WALK_BACK: begin
                    if (d == 0) begin
                        walk_depth = 0;
                        walk_phase = lass_pkg::PH_DONE;
                        return r;
                    end
                    d--;
                    if (walk_bits[d] && walk_ones > 0) walk_ones--;
                    mode = walk_marks[d] ? WALK_BACK : WALK_ZERO;
                end
                default: begin
                    walk_bits[d]  = 1'b0;
                    walk_marks[d] = 1'b1;
                    if (prefix_fits(d + 1, len)) begin
                        d++;
                        mode = WALK_ENTER;
                    end else begin
                        mode = WALK_BACK;
                    end
                end
            endcase
        end
    endfunction

    // ---------------------------------------------------------------
    // channel drivers
    // ---------------------------------------------------------------

    // one search request; valid is left high so back-to-back requests need
    // no second assignment in the same step
    task automatic send_request(input logic restart);
        int gap;
        gap = idle_on ? $urandom_range(0, 10) : 0;
        @(negedge i_clk);
        if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        req_ch.valid   <= 1'b1;
        req_ch.restart <= restart;
        do @(posedge i_clk); while (!req_ch.ready);
        // accepted at this edge, so the model advances now
        hits_due.push_back(next_sequence(restart));
    endtask

    // drop the request line and hold off until every owed result is back
    task automatic wait_all_hits();
        @(negedge i_clk);
        req_ch.valid <= 1'b0;
        while (hits_due.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // only called with no request in flight
    task automatic write_reg(input logic [lass_pkg::ADDR_W-1:0] idx,
                             input logic [lass_pkg::CFG_W-1:0] val);
        @(negedge i_clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.addr  <= idx;
        cfg_ch.data  <= val;
        do @(posedge i_clk); while (!cfg_ch.ready);
        store_reg(idx, val);
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic set_search(input logic [lass_pkg::CFG_W-1:0] len,
                              input logic [lass_pkg::CFG_W-1:0] wgt,
                              input logic [lass_pkg::CFG_W-1:0] corr);
        wait_all_hits();
        write_reg(lass_pkg::REG_SEQ_LENGTH, len);
        write_reg(lass_pkg::REG_TARGET_WEIGHT, wgt);
        write_reg(lass_pkg::REG_MAX_CORR, corr);
    endtask

    // result side: random stall before each result, then hold ready until taken
    initial begin
        int stall;
        res_ch.ready = 1'b0;
        forever begin
            stall = idle_on ? $urandom_range(0, 10) : 0;
            if (stall > 0) begin
                @(negedge i_clk);
                res_ch.ready <= 1'b0;
                repeat (stall - 1) @(negedge i_clk);
            end
            @(negedge i_clk);
            res_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!(res_ch.valid && res_ch.ready));
        end
    end

    // result checker, oldest expectation first
    always @(posedge i_clk) begin
        t_hit want;
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            if (hits_due.size() == 0) begin
                $error("unexpected result: sequence_res %h found %b",
                       res_ch.sequence_res, res_ch.found);
                mismatch_count++;
            end else begin
                want = hits_due.pop_front();
                if (res_ch.sequence_res !== want.seq) begin
                    $error("sequence_res: expected %h, got %h", want.seq, res_ch.sequence_res);
                    mismatch_count++;
                end
                if (res_ch.found !== want.found) begin
                    $error("found: expected %b, got %b", want.found, res_ch.found);
                    mismatch_count++;
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // tests
    // ---------------------------------------------------------------

    // first request after a write starts from scratch even without restart;
    // walk a 3-bit space to exhaustion, then ask again and restart
    task automatic test_idle_start();
        set_search(6'd3, 6'd1, 6'd63);
        send_request(1'b0);
        send_request(1'b0);
        send_request(1'b0);
        // exhausted, then exhausted again
        send_request(1'b0);
        send_request(1'b0);
        send_request(1'b1);
    endtask

    // length above the maximum clamps to 32: all-ones sequence, then nothing
    task automatic test_extreme_lengths();
        set_search(6'd63, 6'd32, 6'd63);
        send_request(1'b1);
        send_request(1'b0);
        // weight beyond the length can never match
        wait_all_hits();
        write_reg(lass_pkg::REG_TARGET_WEIGHT, 6'd63);
        send_request(1'b0);
        // all-ones fails a tight periodic bound
        set_search(6'd32, 6'd32, 6'd31);
        send_request(1'b0);
    endtask

    // lengths below two clamp to two; zero bound rejects every 2-bit sequence
    task automatic test_short_length_clamp();
        set_search(6'd0, 6'd0, 6'd0);
        send_request(1'b0);
        set_search(6'd1, 6'd1, 6'd2);
        send_request(1'b0);
        send_request(1'b0);
        send_request(1'b0);
    endtask

    // a write to the spare index leaves the paused search alone,
    // a write to a real register restarts it
    task automatic test_ignored_index();
        set_search(6'd3, 6'd1, 6'd63);
        send_request(1'b0);
        wait_all_hits();
        write_reg(REG_SPARE, lass_pkg::CFG_W'($urandom_range(0, 63)));
        send_request(1'b0);
        wait_all_hits();
        write_reg(lass_pkg::REG_SEQ_LENGTH, 6'd3);
        send_request(1'b0);
    endtask

    // phases of random settings, mostly short lengths so whole search trees
    // are walked, each followed by a run of requests, mostly continues
    task automatic test_random_search();
        int sent;
        int eff;
        int first;
        int burst;
        logic [lass_pkg::CFG_W-1:0] len_raw;
        sent = 0;
        while (sent < RANDOM_REQUESTS) begin
            wait_all_hits();
            idle_on = ($urandom_range(0, 3) != 0);
            case ($urandom_range(0, 9))
                0:       len_raw = lass_pkg::CFG_W'($urandom_range(0, 1));
                1, 2:    len_raw = lass_pkg::CFG_W'($urandom_range(9, 10));
                default: len_raw = lass_pkg::CFG_W'($urandom_range(2, 8));
            endcase
            eff = (len_raw < lass_pkg::MIN_LEN) ? lass_pkg::MIN_LEN : int'(len_raw);
            // registers written in a rotated order, some skipped now and then
            first = $urandom_range(0, 3);
            for (int k = 0; k < 4; k++) begin
                case ((first + k) % 4)
                    lass_pkg::REG_SEQ_LENGTH:
                        if ($urandom_range(0, 4) != 0)
                            write_reg(lass_pkg::REG_SEQ_LENGTH, len_raw);
                    lass_pkg::REG_TARGET_WEIGHT:
                        if ($urandom_range(0, 4) != 0)
                            write_reg(lass_pkg::REG_TARGET_WEIGHT,
                                      ($urandom_range(0, 7) == 0) ?
                                      lass_pkg::CFG_W'($urandom_range(eff + 1, 63)) :
                                      lass_pkg::CFG_W'($urandom_range(0, eff)));
                    lass_pkg::REG_MAX_CORR:
                        if ($urandom_range(0, 4) != 0)
                            write_reg(lass_pkg::REG_MAX_CORR,
                                      ($urandom_range(0, 4) == 0) ?
                                      lass_pkg::CFG_W'($urandom_range(eff, 63)) :
                                      lass_pkg::CFG_W'($urandom_range(0, eff)));
                    default:
                        if ($urandom_range(0, 5) == 0)
                            write_reg(REG_SPARE, lass_pkg::CFG_W'($urandom_range(0, 63)));
                endcase
            end
            // skipped length write leaves an older length in place
            if (int'(cfg_len) > 10) write_reg(lass_pkg::REG_SEQ_LENGTH, len_raw);
            burst = $urandom_range(2, 10);
            for (int j = 0; j < burst; j++) begin
                send_request(($urandom_range(0, 7) == 0) ? 1'b1 : 1'b0);
                sent++;
            end
        end
    endtask

    // ---------------------------------------------------------------
    // main sequence
    // ---------------------------------------------------------------

    initial begin
        i_rst_n        = 1'b0;
        req_ch.valid   = 1'b0;
        req_ch.restart = 1'b0;
        cfg_ch.valid   = 1'b0;
        cfg_ch.addr    = '0;
        cfg_ch.data    = '0;
        mismatch_count = 0;
        idle_on        = 1'b1;
        reset_search_model();
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_idle_start();
        test_extreme_lengths();
        test_short_length_clamp();
        test_ignored_index();
        test_random_search();

        // drain, then give any stray result time to show up
        wait_all_hits();
        repeat (50) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

// ----- low_autocorrelation_sequence_search.f -----
rtl/core/lass_pkg.sv
rtl/core/lass_if.sv
rtl/core/lass_corr.sv
rtl/core/low_autocorrelation_sequence_search.sv
dv/tb_low_autocorrelation_sequence_search.sv
